// ===== rtl/core/vpy_pkg.sv =====
// Shared constants, types and the arctangent table for the pitch/yaw block.
`default_nettype none
package vpy_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int INT_FRAC        = 16;
  localparam int DIFF_W          = COORD_WIDTH + 1;
  localparam int VEC_W           = 64;
  localparam int ANG_W           = 26;
  localparam int PRESHIFT        = 58 - COORD_WIDTH;
  localparam int GAIN_SHIFT      = 26;
  localparam int GAIN_W          = 28;
  localparam int PROD_W          = DIFF_W + 1 + GAIN_W;
  localparam int PITCH_W         = 16;
  localparam int YAW_W           = 17;

  localparam logic signed [GAIN_W-1:0] GAIN_Q26 = 28'sd110512210;
  localparam logic signed [ANG_W-1:0]  DEG90    = 26'sd5898240;

  typedef struct packed {
    logic                    zero;
    logic                    up;
    logic signed [ANG_W-1:0] zy;
    logic signed [VEC_W-1:0] py;
  } side_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      0:       r = 26'sd2949120;
      1:       r = 26'sd1740967;
      2:       r = 26'sd919879;
      3:       r = 26'sd466945;
      4:       r = 26'sd234379;
      5:       r = 26'sd117304;
      6:       r = 26'sd58666;
      7:       r = 26'sd29335;
      8:       r = 26'sd14668;
      9:       r = 26'sd7334;
      10:      r = 26'sd3667;
      11:      r = 26'sd1833;
      12:      r = 26'sd917;
      13:      r = 26'sd458;
      14:      r = 26'sd229;
      15:      r = 26'sd115;
      16:      r = 26'sd57;
      17:      r = 26'sd29;
      18:      r = 26'sd14;
      19:      r = 26'sd7;
      20:      r = 26'sd4;
      21:      r = 26'sd2;
      22:      r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vpy_prep.sv =====
// Front end: coordinate differences, dz gain scaling and quadrant pre-rotation.
`default_nettype none
module vpy_prep (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    en_i,
  input  wire logic                                    valid_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  start_x_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  start_y_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  start_z_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  end_x_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  end_y_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0]  end_z_i,
  output logic                                         valid_o,
  output logic signed [vpy_pkg::VEC_W-1:0]             x_o,
  output logic signed [vpy_pkg::VEC_W-1:0]             y_o,
  output logic signed [vpy_pkg::ANG_W-1:0]             z_o,
  output vpy_pkg::side_t                               side_o
);

  localparam int DW = vpy_pkg::DIFF_W;
  localparam int VW = vpy_pkg::VEC_W;

  logic                 va_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [DW:0]   ndz_q;
  logic signed [DW-1:0] dx_d, dy_d;
  logic signed [DW:0]   ndz_d;

  logic                    vb_q;
  logic signed [VW-1:0]    x_q, y_q, x_d, y_d;
  logic signed [vpy_pkg::ANG_W-1:0] z_q, z_d;
  vpy_pkg::side_t          side_q, side_d;
  logic signed [VW-1:0]    sx, sy;
  logic signed [vpy_pkg::PROD_W-1:0] prod;

  // Form exact differences; dz is kept negated for the pitch leg
  assign dx_d  = DW'(end_x_i) - DW'(start_x_i);
  assign dy_d  = DW'(end_y_i) - DW'(start_y_i);
  assign ndz_d = (DW + 1)'(start_z_i) - (DW + 1)'(end_z_i);

  // Scale into the vector format and rotate the left half plane by 90 degrees
  assign sx   = VW'(dx_q) <<< vpy_pkg::PRESHIFT;
  assign sy   = VW'(dy_q) <<< vpy_pkg::PRESHIFT;
  assign prod = vpy_pkg::PROD_W'(ndz_q) * vpy_pkg::PROD_W'(vpy_pkg::GAIN_Q26);

  always_comb begin
    x_d = sx;
    y_d = sy;
    z_d = '0;
    if (dx_q < 0) begin
      if (dy_q >= 0) begin
        x_d = sy;
        y_d = -sx;
        z_d = vpy_pkg::DEG90;
      end else begin
        x_d = -sy;
        y_d = sx;
        z_d = -vpy_pkg::DEG90;
      end
    end
    side_d.zero = (dx_q == '0) && (dy_q == '0);
    side_d.up   = (ndz_q >= 0);
    side_d.zy   = '0;
    side_d.py   = VW'(prod) <<< (vpy_pkg::PRESHIFT - vpy_pkg::GAIN_SHIFT);
  end

  // Advance both front stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      ndz_q  <= ndz_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vb_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ===== rtl/core/vpy_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
`default_nettype none
module vpy_cordic (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic signed [vpy_pkg::VEC_W-1:0]    x_i,
  input  wire logic signed [vpy_pkg::VEC_W-1:0]    y_i,
  input  wire logic signed [vpy_pkg::ANG_W-1:0]    z_i,
  input  wire vpy_pkg::side_t                      side_i,
  output logic                                     valid_o,
  output logic signed [vpy_pkg::VEC_W-1:0]         x_o,
  output logic signed [vpy_pkg::VEC_W-1:0]         y_o,
  output logic signed [vpy_pkg::ANG_W-1:0]         z_o,
  output vpy_pkg::side_t                           side_o
);

  localparam int N  = vpy_pkg::CORDIC_STAGES;
  localparam int VW = vpy_pkg::VEC_W;
  localparam int AW = vpy_pkg::ANG_W;

  logic                 v_q [N];
  logic signed [VW-1:0] x_q [N];
  logic signed [VW-1:0] y_q [N];
  logic signed [AW-1:0] z_q [N];
  vpy_pkg::side_t       s_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 vp;
    logic signed [VW-1:0] xp, yp, xs, ys, x_d, y_d;
    logic signed [AW-1:0] zp, z_d;
    vpy_pkg::side_t       sp;

    // Pick the previous stage, or the pass input for the first one
    if (i == 0) begin : g_first
      assign vp = valid_i;
      assign xp = x_i;
      assign yp = y_i;
      assign zp = z_i;
      assign sp = side_i;
    end else begin : g_next
      assign vp = v_q[i-1];
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign sp = s_q[i-1];
    end

    // Rotate toward the x axis by atan(2^-i)
    assign xs = xp >>> i;
    assign ys = yp >>> i;
    always_comb begin
      if (yp >= 0) begin
        x_d = xp + ys;
        y_d = yp - xs;
        z_d = zp + vpy_pkg::atan_deg(i);
      end else begin
        x_d = xp - ys;
        y_d = yp + xs;
        z_d = zp - vpy_pkg::atan_deg(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
        s_q[i] <= sp;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign x_o     = x_q[N-1];
  assign y_o     = y_q[N-1];
  assign z_o     = z_q[N-1];
  assign side_o  = s_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/vpy_round.sv =====
// Output stage: round angles to the output format, saturate and hold the word.
`default_nettype none
module vpy_round (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [vpy_pkg::ANG_W-1:0]  zp_i,
  input  wire vpy_pkg::side_t                    side_i,
  output logic                                   valid_o,
  output logic signed [vpy_pkg::PITCH_W-1:0]     pitch_deg_o,
  output logic signed [vpy_pkg::YAW_W-1:0]       yaw_deg_o
);

  localparam int RW = vpy_pkg::ANG_W + 1;
  localparam int RS = vpy_pkg::INT_FRAC - vpy_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] HALF  = RW'(1) <<< (RS - 1);
  localparam logic signed [RW-1:0] LIM_P = RW'(89) <<< vpy_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] LIM_Y = RW'(180) <<< vpy_pkg::ANGLE_FRAC_BITS;

  // Round half away from zero, then saturate to +-lim
  function automatic logic signed [RW-1:0] round_sat(
    input logic signed [vpy_pkg::ANG_W-1:0] v,
    input logic signed [RW-1:0]             lim
  );
    logic signed [RW-1:0] a, r;
    a = (v < 0) ? -RW'(v) : RW'(v);
    r = (a + HALF) >>> RS;
    if (v < 0) r = -r;
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  logic                               v_q;
  logic signed [vpy_pkg::PITCH_W-1:0] p_q, p_d;
  logic signed [vpy_pkg::YAW_W-1:0]   y_q, y_d;
  logic signed [RW-1:0]               pr, yr;

  assign pr = round_sat(zp_i, LIM_P);
  assign yr = round_sat(side_i.zy, LIM_Y);

  // Select the straight up or down answer for a vertical direction
  always_comb begin
    if (side_i.zero) begin
      p_d = side_i.up ? vpy_pkg::PITCH_W'(LIM_P) : vpy_pkg::PITCH_W'(-LIM_P);
      y_d = '0;
    end else begin
      p_d = vpy_pkg::PITCH_W'(pr);
      y_d = vpy_pkg::YAW_W'(yr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      y_q <= y_d;
    end
  end

  assign valid_o     = v_q;
  assign pitch_deg_o = p_q;
  assign yaw_deg_o   = y_q;

endmodule
`default_nettype wire

// ===== rtl/core/vector_to_pitch_yaw.sv =====
// Top level: direction vector to pitch and yaw angles through two CORDIC passes.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+--------------------------------------
//   in      | in_valid_i  | in_stall_o   | start_{x,y,z}_i, end_{x,y,z}_i
//   out     | out_valid_o | out_stall_i  | pitch_deg_o, yaw_deg_o
//
// One word enters per cycle while the output is not stalled; the yaw pass feeds
// its horizontal magnitude into the pitch pass.
// Reset clears only the valid bits of every stage.
// The whole pipeline holds when the output word is stalled, bubbles included;
// in_stall_o follows out_stall_i in the same cycle while a word is waiting.
`default_nettype none
module vector_to_pitch_yaw (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [vpy_pkg::COORD_WIDTH-1:0] end_z_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [vpy_pkg::PITCH_W-1:0]          pitch_deg_o,
  output logic signed [vpy_pkg::YAW_W-1:0]            yaw_deg_o
);

  logic                                en;
  logic                                pv, yv, tv;
  logic signed [vpy_pkg::VEC_W-1:0]    px, py, yx, yy, tx, ty;
  logic signed [vpy_pkg::ANG_W-1:0]    pz, yz, tz;
  vpy_pkg::side_t                      ps, ys, ts, pitch_side;

  // Advance unless a finished word is waiting on a stalled output
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  vpy_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .valid_o(pv), .x_o(px), .y_o(py), .z_o(pz), .side_o(ps)
  );

  vpy_cordic u_yaw (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv),
    .x_i(px), .y_i(py), .z_i(pz), .side_i(ps),
    .valid_o(yv), .x_o(yx), .y_o(yy), .z_o(yz), .side_o(ys)
  );

  // Carry the yaw angle forward; the horizontal magnitude becomes the x leg
  always_comb begin
    pitch_side    = ys;
    pitch_side.zy = yz;
    pitch_side.py = yy;
  end

  vpy_cordic u_pitch (
    .clk_i, .rst_ni, .en_i(en), .valid_i(yv),
    .x_i(yx), .y_i(ys.py), .z_i('0), .side_i(pitch_side),
    .valid_o(tv), .x_o(tx), .y_o(ty), .z_o(tz), .side_o(ts)
  );

  vpy_round u_round (
    .clk_i, .rst_ni, .en_i(en), .valid_i(tv), .zp_i(tz), .side_i(ts),
    .valid_o(out_valid_o), .pitch_deg_o, .yaw_deg_o
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for vector_to_pitch_yaw: directed table plus random directions, checked by a predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vpy_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int LATENCY   = 2 + 2 * CORDIC_STAGES + 1;
  localparam int N_RANDOM  = 450;
  localparam int CALM_TAIL = 60;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t                    sx, sy, sz, ex, ey, ez;
    logic                      has_angles;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
  } dir_row_t;

  typedef struct {
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
  } angles_t;

  localparam logic signed [PITCH_W-1:0] PITCH_LIM = 16'sd22784;
  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  coord_t start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i;
  logic signed [PITCH_W-1:0] pitch_deg_o;
  logic signed [YAW_W-1:0]   yaw_deg_o;

  angles_t angles_q[$];
  int      n_errors, n_words, n_results, n_zero_horiz;
  logic    calm;

  vector_to_pitch_yaw dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // Vectoring CORDIC over 64-bit vectors; leaves the magnitude in x
  function automatic longint rotate_to_axis(inout longint x, inout longint y, input longint z);
    longint xs, ys;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_deg(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_deg(i));
      end
    end
    return z;
  endfunction

  function automatic longint round_angle(input longint v, input longint lim);
    longint r, half;
    half = 64'sd1 <<< (INT_FRAC - ANGLE_FRAC_BITS - 1);
    if (v >= 0) r = (v + half) >>> (INT_FRAC - ANGLE_FRAC_BITS);
    else r = -((-v + half) >>> (INT_FRAC - ANGLE_FRAC_BITS));
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t predict_angles(input dir_row_t w);
    angles_t a;
    longint dx, dy, dz, x, y, t, z0, zy, zp, px, py;
    dx = longint'(w.ex) - longint'(w.sx);
    dy = longint'(w.ey) - longint'(w.sy);
    dz = longint'(w.ez) - longint'(w.sz);
    if (dx == 0 && dy == 0) begin
      a.pitch = (dz <= 0) ? PITCH_LIM : -PITCH_LIM;
      a.yaw   = '0;
      return a;
    end
    x = dx <<< PRESHIFT;
    y = dy <<< PRESHIFT;
    z0 = 0;
    // fold the left half-plane into the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z0 = longint'(DEG90);
      end else begin
        x = -y; y = t; z0 = -longint'(DEG90);
      end
    end
    zy = rotate_to_axis(x, y, z0);
    px = x;
    py = -(dz * longint'(GAIN_Q26)) * (64'sd1 <<< (PRESHIFT - GAIN_SHIFT));
    zp = rotate_to_axis(px, py, 0);
    a.yaw   = YAW_W'(round_angle(zy, 180 <<< ANGLE_FRAC_BITS));
    a.pitch = PITCH_W'(round_angle(zp, 89 <<< ANGLE_FRAC_BITS));
    return a;
  endfunction

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 64)) - 32;
      2: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
      default: return coord_t'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // Send one word, holding it through stalls
  task automatic send_word(input dir_row_t w);
    angles_t a;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= w.sx; start_y_i <= w.sy; start_z_i <= w.sz;
    end_x_i <= w.ex; end_y_i <= w.ey; end_z_i <= w.ez;
    do @(posedge clk_i); while (in_stall_o);
    a = predict_angles(w);
    if (w.has_angles && (a.pitch != w.pitch || a.yaw != w.yaw))
      report_mismatch("table vs predictor", {a.pitch, a.yaw}, {w.pitch, w.yaw});
    if (w.has_angles) begin
      a.pitch = w.pitch; a.yaw = w.yaw;
    end
    angles_q.push_back(a);
    if (w.ex == w.sx && w.ey == w.sy) n_zero_horiz++;
    n_words++;
  endtask

  // Output stall in bursts, none at the end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (out_stall_i) begin
      out_stall_i <= ($urandom_range(0, 2) != 0);
    end else begin
      out_stall_i <= ($urandom_range(0, 5) == 0);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angles_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = angles_q.pop_front();
        if (pitch_deg_o !== e.pitch) report_mismatch("pitch_deg", pitch_deg_o, e.pitch);
        if (yaw_deg_o !== e.yaw) report_mismatch("yaw_deg", yaw_deg_o, e.yaw);
        n_results++;
      end
    end
  end

  dir_row_t dir_table[$];

  initial begin
    dir_row_t w;
    int mode, guard;
    rst_ni = 1'b0; in_valid_i = 1'b0; calm = 1'b0;
    start_x_i = '0; start_y_i = '0; start_z_i = '0;
    end_x_i = '0; end_y_i = '0; end_z_i = '0;
    n_errors = 0; n_words = 0; n_results = 0; n_zero_horiz = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: zero horizontal, axes, pi boundary, extremes
    dir_table = '{
      '{0, 0, 0, 0, 0, 0, 1, PITCH_LIM, 17'sd0},
      '{0, 0, 5, 0, 0, 0, 1, PITCH_LIM, 17'sd0},
      '{0, 0, 0, 0, 0, 7, 1, -PITCH_LIM, 17'sd0},
      '{7, 7, CMAX, 7, 7, CMIN, 1, PITCH_LIM, 17'sd0},
      '{7, 7, CMIN, 7, 7, CMAX, 1, -PITCH_LIM, 17'sd0},
      '{0, 0, 0, 1, 0, 0, 0, 0, 0},
      '{0, 0, 0, -1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{0, 0, 0, 0, -1, 0, 0, 0, 0},
      '{CMAX, 0, 0, CMIN, 0, 0, 0, 0, 0},
      '{CMIN, 0, 0, CMAX, 0, 0, 0, 0, 0},
      '{0, CMIN, 0, 0, CMAX, 0, 0, 0, 0},
      '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0},
      '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0},
      '{0, 0, CMAX, 1, 0, CMIN, 0, 0, 0},
      '{0, 0, CMIN, 1, 0, CMAX, 0, 0, 0},
      '{0, 0, 0, -5, -1, 3, 0, 0, 0},
      '{0, 0, 0, -5, 1, -3, 0, 0, 0},
      '{0, 0, 0, 3, 3, -4, 0, 0, 0},
      '{0, 0, 0, -3, 0, 1000, 0, 0, 0}
    };
    foreach (dir_table[i]) send_word(dir_table[i]);

    // Random directions of mixed magnitude
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      mode = $urandom_range(0, 3);
      w.has_angles = 1'b0; w.pitch = '0; w.yaw = '0;
      w.sx = rand_coord(mode); w.sy = rand_coord(mode); w.sz = rand_coord(mode);
      w.ex = rand_coord(mode); w.ey = rand_coord(mode); w.ez = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        w.ex = w.sx; w.ey = w.sy;
      end
      send_word(w);
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    guard = 0;
    while (angles_q.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    if (angles_q.size() != 0) report_mismatch("results missing", angles_q.size(), 0);
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("sent %0d directions (%0d with no horizontal part), checked %0d results",
             n_words, n_zero_horiz, n_results);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/vpy_pkg.sv
rtl/core/vpy_prep.sv
rtl/core/vpy_cordic.sv
rtl/core/vpy_round.sv
rtl/core/vector_to_pitch_yaw.sv
tb/testbench.sv
